// ----- design/bats_pkg.sv -----
// ----------------------------------------------------------------------------
// bats_pkg: shared types and constants for the best-arm tracking selector
// Holds the payload structs, command and op codes, config indexes and the
// back-end sequencer states.
// ----------------------------------------------------------------------------
package bats_pkg;

  localparam int MAX_ARMS_DEF = 64;
  localparam int FRAC_BITS    = 16;
  localparam int SUM_W        = 48;
  localparam int CNT_W        = 24;
  localparam int WGT_W        = 17;
  localparam int TOT_W        = 30;
  localparam int ARM_W        = 6;
  localparam int UCNT_W       = 7;
  localparam int CMD_W        = 2;
  localparam int ARMS_CFG_W   = 7;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRACK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARMS = 1'b1;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_TRACK,
    OP_SWAP
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CNT_W-1:0] arm_count;
    logic [WGT_W-1:0] arm_weight;
    logic [ARM_W-1:0] swap_first;
    logic [ARM_W-1:0] swap_second;
  } in_item_t;

  typedef struct packed {
    logic [ARM_W-1:0]  chosen_arm;
    logic [UCNT_W-1:0] undersampled_count;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] arm_count;
    logic [WGT_W-1:0] arm_weight;
    logic [ARM_W-1:0] swap_first;
    logic [ARM_W-1:0] swap_second;
  } job_t;

  typedef struct packed {
    logic                  tracking_mode;
    logic [ARMS_CFG_W-1:0] num_arms;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWAP_B,
    ST_SWAP_WA,
    ST_SWAP_WB,
    ST_P1_RD,
    ST_P1_SQ,
    ST_P1_CMP,
    ST_DIV,
    ST_P2_RD,
    ST_P2_SQ,
    ST_P2_W,
    ST_P2_PROD,
    ST_P2_CMP,
    ST_DONE
  } st_t;

endpackage

// ----- design/bats_front.sv -----
// ----------------------------------------------------------------------------
// bats_front: input decode and job queue
// Accepts input beats, turns commands into ops, drops unused commands and
// queues the jobs for the back end.
// ----------------------------------------------------------------------------
module bats_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bats_pkg::in_item_t in_data,
  output logic               job_valid,
  output bats_pkg::job_t     job,
  input  logic               job_ready
);

  localparam int QA_W = (bats_pkg::QUEUE_DEPTH > 1) ? $clog2(bats_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(bats_pkg::QUEUE_DEPTH + 1);

  bats_pkg::job_t  q_mem_r [bats_pkg::QUEUE_DEPTH];
  logic [QA_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  bats_pkg::job_t  dec;
  logic            dec_ok;
  logic            push, pop;

  // classify the command
  always_comb begin
    dec.arm_count   = in_data.arm_count;
    dec.arm_weight  = in_data.arm_weight;
    dec.swap_first  = in_data.swap_first;
    dec.swap_second = in_data.swap_second;
    dec.op          = bats_pkg::OP_INIT;
    dec_ok          = 1'b1;
    case (in_data.command)
      bats_pkg::CMD_INIT:  dec.op = bats_pkg::OP_INIT;
      bats_pkg::CMD_TRACK: dec.op = bats_pkg::OP_TRACK;
      bats_pkg::CMD_SWAP:  dec.op = bats_pkg::OP_SWAP;
      default:             dec_ok = 1'b0;
    endcase
  end

  assign in_stall  = (cnt_r == QC_W'(bats_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall && dec_ok;
  assign job_valid = (cnt_r != '0);
  assign job       = q_mem_r[rp_r];
  assign pop       = job_valid && job_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QA_W'(bats_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QA_W'(bats_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= dec;
    end
  end

endmodule

// ----- design/bats_back.sv -----
// ----------------------------------------------------------------------------
// bats_back: arm store and batch sequencer
// Holds sums, counts and weights, runs swaps and the end-of-batch scans,
// reciprocal and argmin, and drives the result register.
// ----------------------------------------------------------------------------
module bats_back #(
  parameter int MAX_ARMS = bats_pkg::MAX_ARMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bats_pkg::cfg_t      cfg,
  input  logic                job_valid,
  input  bats_pkg::job_t      job,
  output logic                job_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output bats_pkg::out_item_t out_data
);

  localparam int AW     = $clog2(MAX_ARMS);
  localparam int KW0    = $clog2(MAX_ARMS + 1);
  localparam int KW     = (KW0 > bats_pkg::ARMS_CFG_W) ? KW0 : bats_pkg::ARMS_CFG_W;
  localparam int LHS_W  = bats_pkg::CNT_W + 2;
  localparam int SQ_W   = 2 * LHS_W;
  localparam int V_W    = bats_pkg::SUM_W + 2;
  localparam int Q_W    = bats_pkg::FRAC_BITS + 1;
  localparam int DC_W   = $clog2(Q_W);
  localparam int SUM_W  = bats_pkg::SUM_W;
  localparam int CNT_W  = bats_pkg::CNT_W;
  localparam int WGT_W  = bats_pkg::WGT_W;
  localparam int TOT_W  = bats_pkg::TOT_W;

  logic [SUM_W-1:0] sum_mem [MAX_ARMS];
  logic [CNT_W-1:0] cnt_mem [MAX_ARMS];
  logic [WGT_W-1:0] wgt_mem [MAX_ARMS];

  bats_pkg::st_t    state_r, state_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [TOT_W-1:0] t_r, t_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [KW-1:0]    num_r, num_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [KW-1:0]    rem_r, rem_nxt;
  logic [DC_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [WGT_W-1:0] w_r, w_nxt;
  logic [SUM_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0] nsum_r, nsum_nxt;
  logic [AW-1:0]    best_r, best_nxt;
  logic signed [V_W-1:0] best_v_r, best_v_nxt;
  logic [AW-1:0]    swap_a_r, swap_a_nxt, swap_b_r, swap_b_nxt;
  logic [SUM_W-1:0] tmp_r, tmp_nxt;
  bats_pkg::out_item_t out_data_r, out_data_nxt;

  logic [SUM_W-1:0] sum_q_r;
  logic [CNT_W-1:0] cnt_q_r;
  logic [WGT_W-1:0] wgt_q_r;

  logic [AW-1:0]    raddr, sum_waddr;
  logic             sum_we, cw_we;
  logic [SUM_W-1:0] sum_wdata;

  logic [KW-1:0]    k;
  logic [KW-1:0]    num_ext;
  logic             pos_last, idx_last, swap_ok, under;
  logic [TOT_W:0]   tot_sum;
  logic [TOT_W-1:0] tot_sat;
  logic [LHS_W-1:0] lhs;
  logic [SQ_W-1:0]  t4;
  logic [KW:0]      rem_sh;
  logic             div_bit;
  logic [SUM_W:0]   sum_add;
  logic [V_W-1:0]   nfx;
  logic [SUM_W-1:0] term;
  logic signed [V_W-1:0] v;
  logic [KW-1:0]    num_p1;

  assign num_ext = KW'(cfg.num_arms);
  assign k = (num_ext == '0) ? KW'(1)
           : ((num_ext > KW'(MAX_ARMS)) ? KW'(MAX_ARMS) : num_ext);

  assign pos_last = ((KW+1)'(pos_r) + 1'b1) >= (KW+1)'(k);
  assign idx_last = ((KW+1)'(idx_r) + 1'b1) >= (KW+1)'(k);
  assign swap_ok  = !cfg.tracking_mode && (KW'(job.swap_first) < k)
                    && (KW'(job.swap_second) < k);

  assign tot_sum = (TOT_W+1)'(total_r) + (TOT_W+1)'(job.arm_count);
  assign tot_sat = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];

  assign lhs   = LHS_W'({cnt_q_r, 1'b0}) + LHS_W'(k);
  assign t4    = SQ_W'({t_r, 2'b00});
  assign under = (sq_r <= t4);
  assign num_p1 = num_r + KW'(under);

  assign div_bit = (div_cnt_r == DC_W'(Q_W - 1));
  assign rem_sh  = {rem_r, div_bit};

  assign sum_add = (SUM_W+1)'(sum_q_r) + (SUM_W+1)'(w_r);
  assign nfx     = V_W'({cnt_q_r, {bats_pkg::FRAC_BITS{1'b0}}});
  assign term    = cfg.tracking_mode ? prod_r : nsum_r;
  assign v       = $signed(nfx) - $signed(V_W'(term));

  assign job_ready = (state_r == bats_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    t_nxt         = t_r;
    idx_nxt       = idx_r;
    num_nxt       = num_r;
    sq_nxt        = sq_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    w_nxt         = w_r;
    prod_nxt      = prod_r;
    nsum_nxt      = nsum_r;
    best_nxt      = best_r;
    best_v_nxt    = best_v_r;
    swap_a_nxt    = swap_a_r;
    swap_b_nxt    = swap_b_r;
    tmp_nxt       = tmp_r;
    out_data_nxt  = out_data_r;
    raddr         = idx_r;
    sum_we        = 1'b0;
    sum_waddr     = idx_r;
    sum_wdata     = nsum_r;
    cw_we         = 1'b0;

    case (state_r)
      bats_pkg::ST_IDLE: begin
        if (job_valid) begin
          case (job.op)
            bats_pkg::OP_INIT: begin
              sum_we    = 1'b1;
              sum_waddr = pos_r;
              sum_wdata = SUM_W'({job.arm_count, {bats_pkg::FRAC_BITS{1'b0}}});
              pos_nxt   = pos_last ? '0 : pos_r + 1'b1;
            end
            bats_pkg::OP_TRACK: begin
              cw_we = 1'b1;
              if (pos_last) begin
                t_nxt     = tot_sat;
                total_nxt = '0;
                pos_nxt   = '0;
                idx_nxt   = '0;
                num_nxt   = '0;
                state_nxt = bats_pkg::ST_P1_RD;
              end else begin
                total_nxt = tot_sat;
                pos_nxt   = pos_r + 1'b1;
              end
            end
            bats_pkg::OP_SWAP: begin
              if (swap_ok) begin
                raddr      = AW'(job.swap_first);
                swap_a_nxt = AW'(job.swap_first);
                swap_b_nxt = AW'(job.swap_second);
                state_nxt  = bats_pkg::ST_SWAP_B;
              end
            end
            default: ;
          endcase
        end
      end
      bats_pkg::ST_SWAP_B: begin
        raddr     = swap_b_r;
        tmp_nxt   = sum_q_r;
        state_nxt = bats_pkg::ST_SWAP_WA;
      end
      bats_pkg::ST_SWAP_WA: begin
        sum_we    = 1'b1;
        sum_waddr = swap_a_r;
        sum_wdata = sum_q_r;
        state_nxt = bats_pkg::ST_SWAP_WB;
      end
      bats_pkg::ST_SWAP_WB: begin
        sum_we    = 1'b1;
        sum_waddr = swap_b_r;
        sum_wdata = tmp_r;
        state_nxt = bats_pkg::ST_IDLE;
      end
      bats_pkg::ST_P1_RD: begin
        state_nxt = bats_pkg::ST_P1_SQ;
      end
      bats_pkg::ST_P1_SQ: begin
        sq_nxt    = SQ_W'(lhs) * SQ_W'(lhs);
        state_nxt = bats_pkg::ST_P1_CMP;
      end
      bats_pkg::ST_P1_CMP: begin
        num_nxt = num_p1;
        if (idx_last) begin
          idx_nxt = '0;
          if (num_p1 == '0) begin
            state_nxt = bats_pkg::ST_P2_RD;
          end else begin
            rem_nxt     = '0;
            q_nxt       = '0;
            div_cnt_nxt = DC_W'(Q_W - 1);
            state_nxt   = bats_pkg::ST_DIV;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = bats_pkg::ST_P1_RD;
        end
      end
      bats_pkg::ST_DIV: begin
        // one quotient bit per cycle, restoring
        if (rem_sh >= {1'b0, num_r}) begin
          rem_nxt = KW'(rem_sh - {1'b0, num_r});
          q_nxt   = {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[KW-1:0];
          q_nxt   = {q_r[Q_W-2:0], 1'b0};
        end
        if (div_cnt_r == '0) begin
          state_nxt = bats_pkg::ST_P2_RD;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      bats_pkg::ST_P2_RD: begin
        state_nxt = bats_pkg::ST_P2_SQ;
      end
      bats_pkg::ST_P2_SQ: begin
        sq_nxt    = SQ_W'(lhs) * SQ_W'(lhs);
        state_nxt = bats_pkg::ST_P2_W;
      end
      bats_pkg::ST_P2_W: begin
        if (num_r != '0) begin
          w_nxt = under ? WGT_W'(q_r) : '0;
        end else begin
          w_nxt = wgt_q_r;
        end
        state_nxt = bats_pkg::ST_P2_PROD;
      end
      bats_pkg::ST_P2_PROD: begin
        prod_nxt  = SUM_W'(t_r) * SUM_W'(w_r);
        nsum_nxt  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        state_nxt = bats_pkg::ST_P2_CMP;
      end
      bats_pkg::ST_P2_CMP: begin
        if (!cfg.tracking_mode) begin
          sum_we = 1'b1;
        end
        if ((idx_r == '0) || (v < best_v_r)) begin
          best_nxt   = idx_r;
          best_v_nxt = v;
        end
        if (idx_last) begin
          state_nxt = bats_pkg::ST_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = bats_pkg::ST_P2_RD;
        end
      end
      bats_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.chosen_arm         = bats_pkg::ARM_W'(best_r);
          out_data_nxt.undersampled_count = bats_pkg::UCNT_W'(num_r);
          state_nxt                       = bats_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bats_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bats_pkg::ST_IDLE;
      pos_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    idx_r      <= idx_nxt;
    num_r      <= num_nxt;
    sq_r       <= sq_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    w_r        <= w_nxt;
    prod_r     <= prod_nxt;
    nsum_r     <= nsum_nxt;
    best_r     <= best_nxt;
    best_v_r   <= best_v_nxt;
    swap_a_r   <= swap_a_nxt;
    swap_b_r   <= swap_b_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
  end

  // arm store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (cw_we) begin
      cnt_mem[pos_r] <= job.arm_count;
      wgt_mem[pos_r] <= job.arm_weight;
    end
    sum_q_r <= sum_mem[raddr];
    cnt_q_r <= cnt_mem[raddr];
    wgt_q_r <= wgt_mem[raddr];
  end

endmodule

// ----- design/best_arm_tracking_selector.sv -----
// ----------------------------------------------------------------------------
// best_arm_tracking_selector: C/D tracking arm picker
// Collects per-arm counts and weights, then picks the next arm to sample
// with forced exploration of undersampled arms.
// ----------------------------------------------------------------------------
//
//   channel   handshake            beat
//   -------   ------------------   -------------------------------------
//   in        in_valid / in_stall  bats_pkg::in_item_t (command, count..)
//   out       out_valid/out_stall  bats_pkg::out_item_t (arm, under cnt)
//   cfg       cfg_valid/cfg_ready  cfg_index (0 mode, 1 arms), cfg_data
//
// Init and track beats are taken while the back end is idle; a swap
// exchanges two arm sums. The track beat for the last arm starts the
// batch close: a count scan per arm (read, square, compare), a reciprocal
// when any arm is undersampled, and an argmin pass per arm (read, square,
// weight, product, compare). A result then sits in the output register.
// Reset (rst_n low, synchronous) clears the position, the running total and
// the control state; the arm store is undefined until written.
// A two-entry queue keeps taking beats while the back end is busy; in_stall
// rises only when it is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module best_arm_tracking_selector #(
  parameter int MAX_ARMS = bats_pkg::MAX_ARMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bats_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bats_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bats_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bats_pkg::CFG_DATA_W-1:0]     cfg_data
);

  bats_pkg::cfg_t cfg_r, cfg_nxt;
  logic           job_valid, job_ready;
  bats_pkg::job_t job;

  assign cfg_ready = 1'b1;

  // the user keeps register writes to idle (not enforced); applied at once
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bats_pkg::CFG_MODE: cfg_nxt.tracking_mode = cfg_data[0];
        bats_pkg::CFG_ARMS: cfg_nxt.num_arms      = cfg_data[bats_pkg::ARMS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tracking_mode <= 1'b0;
      cfg_r.num_arms      <= bats_pkg::ARMS_CFG_W'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode and queue
  bats_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  // back: arm store, batch close and result register
  bats_back #(
    .MAX_ARMS (MAX_ARMS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/bats_checker.sv -----
// ----------------------------------------------------------------------------
// bats_checker: result predictor and scoreboard for the arm selector
// Watches the in, out and cfg channels, keeps its own copy of the arm store,
// predicts each batch result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bats_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  bats_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  bats_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bats_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bats_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  open_results
);

  localparam longint unsigned SUM_TOP   = (64'd1 << bats_pkg::SUM_W) - 1;
  localparam longint unsigned TOTAL_TOP = (64'd1 << bats_pkg::TOT_W) - 1;

  logic                            mode_q;
  logic [bats_pkg::ARMS_CFG_W-1:0] arms_q;
  logic [bats_pkg::SUM_W-1:0]      sum_mem [bats_pkg::MAX_ARMS_DEF];
  logic [bats_pkg::CNT_W-1:0]      cnt_mem [bats_pkg::MAX_ARMS_DEF];
  logic [bats_pkg::WGT_W-1:0]      wgt_mem [bats_pkg::MAX_ARMS_DEF];
  int                              pos_q;
  longint unsigned                 total_q;
  bats_pkg::out_item_t             pick_q [$];

  function automatic int arms_used();
    if (arms_q == 0) return 1;
    if (arms_q > bats_pkg::MAX_ARMS_DEF) return bats_pkg::MAX_ARMS_DEF;
    return int'(arms_q);
  endfunction

  // Close a batch: flag undersampled arms, then take the first minimum.
  function automatic bats_pkg::out_item_t pick_arm(int k);
    bit                  under [bats_pkg::MAX_ARMS_DEF];
    int                  num;
    int                  best;
    longint unsigned     lhs;
    longint unsigned     uw;
    longint unsigned     w;
    longint unsigned     s;
    longint              v;
    longint              best_v;
    bats_pkg::out_item_t r;
    num = 0;
    best = 0;
    best_v = 0;
    uw = 0;
    for (int i = 0; i < k; i++) begin
      lhs = 2 * longint'(cnt_mem[i]) + k;
      under[i] = (lhs * lhs) <= 4 * total_q;
      if (under[i]) num++;
    end
    if (num > 0) uw = (64'd1 << bats_pkg::FRAC_BITS) / num;
    for (int i = 0; i < k; i++) begin
      w = (num > 0) ? (under[i] ? uw : 0) : longint'(wgt_mem[i]);
      if (!mode_q) begin
        s = longint'(sum_mem[i]) + w;
        if (s > SUM_TOP) s = SUM_TOP;
        sum_mem[i] = s[bats_pkg::SUM_W-1:0];
        v = (longint'(cnt_mem[i]) << bats_pkg::FRAC_BITS) - longint'(s);
      end else begin
        v = (longint'(cnt_mem[i]) << bats_pkg::FRAC_BITS) - longint'(total_q * w);
      end
      if (i == 0 || v < best_v) begin
        best_v = v;
        best = i;
      end
    end
    r.chosen_arm = best[bats_pkg::ARM_W-1:0];
    r.undersampled_count = num[bats_pkg::UCNT_W-1:0];
    return r;
  endfunction

  task automatic apply_beat(bats_pkg::in_item_t b);
    int                         k;
    int                         p;
    longint unsigned            s;
    logic [bats_pkg::SUM_W-1:0] tmp;
    k = arms_used();
    p = (pos_q < bats_pkg::MAX_ARMS_DEF) ? pos_q : bats_pkg::MAX_ARMS_DEF - 1;
    case (b.command)
      bats_pkg::CMD_INIT: begin
        s = longint'(b.arm_count) << bats_pkg::FRAC_BITS;
        sum_mem[p] = (s > SUM_TOP) ? SUM_TOP[bats_pkg::SUM_W-1:0]
                                   : s[bats_pkg::SUM_W-1:0];
        pos_q = (pos_q + 1 >= k) ? 0 : pos_q + 1;
      end
      bats_pkg::CMD_TRACK: begin
        cnt_mem[p] = b.arm_count;
        wgt_mem[p] = b.arm_weight;
        total_q = total_q + b.arm_count;
        if (total_q > TOTAL_TOP) total_q = TOTAL_TOP;
        if (p + 1 >= k) begin
          pick_q.push_back(pick_arm(k));
          pos_q = 0;
          total_q = 0;
        end else begin
          pos_q = p + 1;
        end
      end
      bats_pkg::CMD_SWAP: begin
        if (!mode_q && b.swap_first < k && b.swap_second < k) begin
          tmp = sum_mem[b.swap_first];
          sum_mem[b.swap_first] = sum_mem[b.swap_second];
          sum_mem[b.swap_second] = tmp;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    bats_pkg::out_item_t exp_r;
    if (!rst_n) begin
      mode_q = 1'b0;
      arms_q = 7'd2;
      pos_q = 0;
      total_q = 0;
      pick_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bats_pkg::CFG_MODE: mode_q = cfg_data[0];
          bats_pkg::CFG_ARMS: arms_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pick_q.size() == 0) begin
          $error("unexpected result beat: chosen_arm %0d undersampled_count %0d",
                 out_data.chosen_arm, out_data.undersampled_count);
          fail_count++;
        end else begin
          exp_r = pick_q.pop_front();
          if (out_data.chosen_arm !== exp_r.chosen_arm) begin
            $error("chosen_arm: expected %0d, got %0d",
                   exp_r.chosen_arm, out_data.chosen_arm);
            fail_count++;
          end
          if (out_data.undersampled_count !== exp_r.undersampled_count) begin
            $error("undersampled_count: expected %0d, got %0d",
                   exp_r.undersampled_count, out_data.undersampled_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) apply_beat(in_data);
    end
    open_results = pick_q.size();
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for best_arm_tracking_selector
// Drives directed and random init, track and swap beats through several
// mode and arm-count settings and idle/stall phases; bats_checker predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  // Command 3 has no function; the block must drop it.
  localparam logic [bats_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_WAIT = 40;    // covers a swap or init still in flight
  localparam int TAIL_WAIT   = 700;   // longer than a 64-arm batch close
  localparam int PHASE_ITEMS = 110;

  logic                rst_n = 1'b0;
  logic                clk = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bats_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bats_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [bats_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bats_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int open_results;
  int cycle_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // Shadow of the arm position and which store entries hold data, so that
  // no batch close or swap ever reads an arm that was never loaded.
  int sel_pos = 0;
  int sel_arms = 2;
  bit sel_mode = 1'b0;
  bit sum_ok [bats_pkg::MAX_ARMS_DEF];
  bit load_ok [bats_pkg::MAX_ARMS_DEF];

  always #5 clk = ~clk;

  best_arm_tracking_selector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bats_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** best_arm_tracking_selector: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Present one beat; enter and leave at a falling edge. Valid stays high
  // into the next beat when no gap is drawn.
  task automatic send_beat(bats_pkg::in_item_t b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(logic [bats_pkg::CFG_IDX_W-1:0] idx,
                           logic [bats_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == bats_pkg::CFG_MODE) begin
      sel_mode = val[0];
    end else begin
      sel_arms = (val == 0) ? 1 : (val > bats_pkg::MAX_ARMS_DEF) ? bats_pkg::MAX_ARMS_DEF
                                                                 : int'(val);
    end
  endtask

  // Hold until every predicted result has arrived, then let short work finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // Send a beat and advance the shadow position the way the block does.
  // A closing track or a C-mode swap that would read an unloaded arm
  // becomes an init.
  task automatic issue(logic [bats_pkg::CMD_W-1:0] cmd, logic [bats_pkg::CNT_W-1:0] n,
                       logic [bats_pkg::WGT_W-1:0] w, logic [bats_pkg::ARM_W-1:0] a,
                       logic [bats_pkg::ARM_W-1:0] b);
    bats_pkg::in_item_t bt;
    int                 p;
    bit                 safe;
    p = (sel_pos < bats_pkg::MAX_ARMS_DEF) ? sel_pos : bats_pkg::MAX_ARMS_DEF - 1;
    if (cmd == bats_pkg::CMD_TRACK && p + 1 >= sel_arms) begin
      safe = 1'b1;
      for (int i = 0; i < sel_arms; i++) begin
        if (i != p && !load_ok[i]) safe = 1'b0;
        if (!sel_mode && !sum_ok[i]) safe = 1'b0;
      end
      if (!safe) cmd = bats_pkg::CMD_INIT;
    end
    if (cmd == bats_pkg::CMD_SWAP && !sel_mode && a < sel_arms && b < sel_arms
        && !(sum_ok[a] && sum_ok[b])) begin
      cmd = bats_pkg::CMD_INIT;
    end
    bt.command = cmd;
    bt.arm_count = n;
    bt.arm_weight = w;
    bt.swap_first = a;
    bt.swap_second = b;
    send_beat(bt);
    if (cmd == bats_pkg::CMD_INIT) begin
      sum_ok[p] = 1'b1;
      sel_pos = (sel_pos + 1 >= sel_arms) ? 0 : sel_pos + 1;
    end else if (cmd == bats_pkg::CMD_TRACK) begin
      load_ok[p] = 1'b1;
      sel_pos = (p + 1 >= sel_arms) ? 0 : p + 1;
    end
  endtask

  function automatic logic [bats_pkg::CNT_W-1:0] draw_count();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      2, 3:    return bats_pkg::CNT_W'($urandom);
      default: return bats_pkg::CNT_W'($urandom_range(300));
    endcase
  endfunction

  function automatic logic [bats_pkg::WGT_W-1:0] draw_weight();
    case ($urandom_range(9))
      0:       return bats_pkg::WGT_W'(1 << bats_pkg::FRAC_BITS);
      1:       return '0;
      default: return bats_pkg::WGT_W'($urandom_range((1 << bats_pkg::FRAC_BITS) - 1));
    endcase
  endfunction

  // Mostly well-formed batches, with init runs, swaps and dropped beats mixed in.
  task automatic random_beat();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      issue(bats_pkg::CMD_TRACK, draw_count(), draw_weight(),
            bats_pkg::ARM_W'($urandom), bats_pkg::ARM_W'($urandom));
    end else if (r < 80) begin
      issue(bats_pkg::CMD_INIT, draw_count(), draw_weight(),
            bats_pkg::ARM_W'($urandom), bats_pkg::ARM_W'($urandom));
    end else if (r < 93) begin
      issue(bats_pkg::CMD_SWAP, draw_count(), draw_weight(),
            bats_pkg::ARM_W'($urandom_range(sel_arms)), bats_pkg::ARM_W'($urandom));
    end else begin
      issue(CMD_UNUSED, draw_count(), draw_weight(),
            bats_pkg::ARM_W'($urandom), bats_pkg::ARM_W'($urandom));
    end
  endtask

  initial begin
    int mode_list [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
    int arms_list [8] = '{1, 64, 64, 3, 0, 127, 8, 5};
    int idle_list [4] = '{0, 54, 0, 7};
    int stall_list [4] = '{0, 0, 54, 7};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings (C mode, two arms), field extremes, every command.
    issue(bats_pkg::CMD_INIT, '0, '0, '0, '0);
    issue(bats_pkg::CMD_INIT, '1, '0, '0, '0);
    issue(bats_pkg::CMD_TRACK, '0, '0, '0, '0);
    issue(bats_pkg::CMD_TRACK, '1, bats_pkg::WGT_W'(1 << bats_pkg::FRAC_BITS), '1, '1);
    issue(bats_pkg::CMD_SWAP, '0, '0, 6'd0, 6'd1);
    issue(bats_pkg::CMD_SWAP, '0, '0, 6'd0, 6'd63);
    issue(CMD_UNUSED, '1, '1, '1, '1);
    // One arm undersampled: count 0 against a total of 100.
    issue(bats_pkg::CMD_TRACK, 24'd0, 17'd40000, '0, '0);
    issue(bats_pkg::CMD_TRACK, 24'd100, 17'd1000, '0, '0);
    // No arm undersampled: all counts zero against a total of zero.
    issue(bats_pkg::CMD_TRACK, '0, 17'd5, '0, '0);
    issue(bats_pkg::CMD_TRACK, '0, 17'd9, '0, '0);
    // Partial init run, then a batch starting mid-way.
    issue(bats_pkg::CMD_INIT, 24'd7, '0, '0, '0);
    issue(bats_pkg::CMD_TRACK, 24'd5000, 17'd123, '0, '0);
    issue(bats_pkg::CMD_TRACK, 24'd6000, 17'd65535, '0, '0);
    drain();
    write_reg(bats_pkg::CFG_MODE, 7'd1);
    issue(bats_pkg::CMD_TRACK, 24'd9000, 17'd30000, '0, '0);
    issue(bats_pkg::CMD_TRACK, 24'd9000, 17'd30001, '0, '0);
    issue(bats_pkg::CMD_SWAP, '0, '0, 6'd0, 6'd1);
    issue(bats_pkg::CMD_TRACK, 24'd3, 17'd1, '0, '0);
    issue(bats_pkg::CMD_TRACK, '1, '1, '0, '0);

    // Random phases across settings and idle/stall patterns.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      idle_pct = 0;
      stall_pct = 0;
      write_reg(bats_pkg::CFG_MODE, bats_pkg::CFG_DATA_W'(mode_list[ph]));
      write_reg(bats_pkg::CFG_ARMS, bats_pkg::CFG_DATA_W'(arms_list[ph]));
      idle_pct = idle_list[ph % 4];
      stall_pct = stall_list[ph % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once mid-run, hold the sender until every result is back.
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (open_results != 0);
        end
        random_beat();
      end
    end

    in_valid <= 1'b0;
    while (open_results != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("** best_arm_tracking_selector: PASSED **");
    end else begin
      $display("** best_arm_tracking_selector: FAILED **");
    end
    $finish;
  end

endmodule
